FILE: rtl/cpc_pkg.sv
// shared types, constants and crc function for the configuration packet checker
`default_nettype none

package cpc_pkg;

    localparam int PACKET_BYTES = 22;
    localparam int CRC_SPAN     = 20;
    localparam int COUNT_W      = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  RESERVED_MASK = 8'hF0;
    localparam logic [7:0]  VERSION_RESET = 8'h01;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MINIMUM_REVISION = 1'b1;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_VERSION  = 3'd2,
        ERR_RESERVED = 3'd3,
        ERR_CRC      = 3'd4,
        ERR_STALE    = 3'd5
    } t_err_code;

    typedef struct packed {
        t_err_code   error_code;
        logic [3:0]  enable_flags;
        logic [31:0] revision;
        logic [31:0] delay_micros;
        logic [15:0] low_pass_decihertz;
        logic [15:0] trim_centidb;
        logic [15:0] shelf_decihertz;
        logic [15:0] shelf_gain_centidb;
    } t_result;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/config_packet_checker.sv
// top level: byte-serial configuration packet check with crc, header and payload capture
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_packet_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall | o_error_code and decoded fields
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one byte is taken per cycle while o_in_stall is low; crc update, capture and the
// checks for a last byte sit between the packet state registers and the result register,
// so a result is registered as its last byte is taken, into the skid if the output stalls.
// reset (synchronous, active low) clears the count, the crc and both result slots.
// a two-entry output (result register plus skid) absorbs one stalled result;
// o_in_stall rises only when both entries hold results.
`default_nettype none

module config_packet_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_packet_byte,
    input  wire logic               i_last_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_error_code,
    output logic [3:0]              o_enable_flags,
    output logic [31:0]             o_revision,
    output logic [31:0]             o_delay_micros,
    output logic [15:0]             o_low_pass_decihertz,
    output logic signed [15:0]      o_trim_centidb,
    output logic [15:0]             o_shelf_decihertz,
    output logic signed [15:0]      o_shelf_gain_centidb,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [cpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [cpc_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [cpc_pkg::COUNT_W-1:0] COUNT_PKT = cpc_pkg::COUNT_W'(cpc_pkg::PACKET_BYTES);
    localparam logic [cpc_pkg::COUNT_W-1:0] COUNT_CRC = cpc_pkg::COUNT_W'(cpc_pkg::CRC_SPAN);

    // configuration
    logic [7:0]  r_expected_version;
    logic [31:0] r_minimum_revision;

    // packet state
    logic [cpc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_length, n_length;
    logic [31:0] r_rev, n_rev;
    logic [31:0] r_delay, n_delay;
    logic [15:0] r_cutoff, n_cutoff;
    logic [15:0] r_trim, n_trim;
    logic [15:0] r_shelf_freq, n_shelf_freq;
    logic [15:0] r_shelf_gain, n_shelf_gain;
    logic [15:0] r_crc_field, n_crc_field;

    // output slots
    logic              r_out_valid, r_skid_valid;
    cpc_pkg::t_result  r_out, r_skid, n_result;

    logic in_accept, out_take, result_new;
    logic [cpc_pkg::COUNT_W-1:0] count_inc;
    cpc_pkg::t_err_code code;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign result_new  = in_accept && i_last_byte;
    assign out_take    = r_out_valid && !i_out_stall;
    assign count_inc   = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_crc        = (r_count < COUNT_CRC) ? cpc_pkg::crc_byte(r_crc, i_packet_byte) : r_crc;
        n_version    = r_version;
        n_flags      = r_flags;
        n_length     = r_length;
        n_rev        = r_rev;
        n_delay      = r_delay;
        n_cutoff     = r_cutoff;
        n_trim       = r_trim;
        n_shelf_freq = r_shelf_freq;
        n_shelf_gain = r_shelf_gain;
        n_crc_field  = r_crc_field;
        case (r_count)
            5'd0:  n_version          = i_packet_byte;
            5'd1:  n_flags            = i_packet_byte;
            5'd2:  n_length[7:0]      = i_packet_byte;
            5'd3:  n_length[15:8]     = i_packet_byte;
            5'd4:  n_rev[7:0]         = i_packet_byte;
            5'd5:  n_rev[15:8]        = i_packet_byte;
            5'd6:  n_rev[23:16]       = i_packet_byte;
            5'd7:  n_rev[31:24]       = i_packet_byte;
            5'd8:  n_delay[7:0]       = i_packet_byte;
            5'd9:  n_delay[15:8]      = i_packet_byte;
            5'd10: n_delay[23:16]     = i_packet_byte;
            5'd11: n_delay[31:24]     = i_packet_byte;
            5'd12: n_cutoff[7:0]      = i_packet_byte;
            5'd13: n_cutoff[15:8]     = i_packet_byte;
            5'd14: n_trim[7:0]        = i_packet_byte;
            5'd15: n_trim[15:8]       = i_packet_byte;
            5'd16: n_shelf_freq[7:0]  = i_packet_byte;
            5'd17: n_shelf_freq[15:8] = i_packet_byte;
            5'd18: n_shelf_gain[7:0]  = i_packet_byte;
            5'd19: n_shelf_gain[15:8] = i_packet_byte;
            5'd20: n_crc_field[7:0]   = i_packet_byte;
            5'd21: n_crc_field[15:8]  = i_packet_byte;
            default: ;
        endcase

        // checks in priority order, on the values after this byte
        if (count_inc != COUNT_PKT || n_length != 16'(cpc_pkg::PACKET_BYTES)) begin
            code = cpc_pkg::ERR_LENGTH;
        end else if (n_version != r_expected_version) begin
            code = cpc_pkg::ERR_VERSION;
        end else if ((n_flags & cpc_pkg::RESERVED_MASK) != 8'h00) begin
            code = cpc_pkg::ERR_RESERVED;
        end else if (n_crc != n_crc_field) begin
            code = cpc_pkg::ERR_CRC;
        end else if (n_rev < r_minimum_revision) begin
            code = cpc_pkg::ERR_STALE;
        end else begin
            code = cpc_pkg::ERR_OK;
        end

        n_result = '0;
        n_result.error_code = code;
        if (code == cpc_pkg::ERR_OK) begin
            n_result.enable_flags       = n_flags[3:0];
            n_result.revision           = n_rev;
            n_result.delay_micros       = n_delay;
            n_result.low_pass_decihertz = n_cutoff;
            n_result.trim_centidb       = n_trim;
            n_result.shelf_decihertz    = n_shelf_freq;
            n_result.shelf_gain_centidb = n_shelf_gain;
        end

        if (i_last_byte) begin
            n_count = '0;
        end else begin
            n_count = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= cpc_pkg::VERSION_RESET;
            r_minimum_revision <= '0;
            r_count            <= '0;
            r_crc              <= cpc_pkg::CRC_INIT;
            r_out_valid        <= 1'b0;
            r_skid_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cpc_pkg::CFG_EXPECTED_VERSION: r_expected_version <= i_cfg_data[7:0];
                    cpc_pkg::CFG_MINIMUM_REVISION: r_minimum_revision <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_count <= n_count;
                r_crc   <= i_last_byte ? cpc_pkg::CRC_INIT : n_crc;
            end

            // result register refills from the skid first, then from a new request
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= result_new;
                end
            end else if (result_new) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_version    <= n_version;
            r_flags      <= n_flags;
            r_length     <= n_length;
            r_rev        <= n_rev;
            r_delay      <= n_delay;
            r_cutoff     <= n_cutoff;
            r_trim       <= n_trim;
            r_shelf_freq <= n_shelf_freq;
            r_shelf_gain <= n_shelf_gain;
            r_crc_field  <= n_crc_field;
        end
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (result_new) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_error_code         = r_out.error_code;
    assign o_enable_flags       = r_out.enable_flags;
    assign o_revision           = r_out.revision;
    assign o_delay_micros       = r_out.delay_micros;
    assign o_low_pass_decihertz = r_out.low_pass_decihertz;
    assign o_trim_centidb       = $signed(r_out.trim_centidb);
    assign o_shelf_decihertz    = r_out.shelf_decihertz;
    assign o_shelf_gain_centidb = $signed(r_out.shelf_gain_centidb);

endmodule

`default_nettype wire

FILE: rtl/cpc_checker.sv
// port-level assertions for the configuration packet checker, bound to the top level
`default_nettype none

module cpc_assertions (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic [7:0]         i_packet_byte,
    input wire logic               i_last_byte,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [2:0]         o_error_code,
    input wire logic [3:0]         o_enable_flags,
    input wire logic [31:0]        o_revision,
    input wire logic [31:0]        o_delay_micros,
    input wire logic [15:0]        o_low_pass_decihertz,
    input wire logic signed [15:0] o_trim_centidb,
    input wire logic [15:0]        o_shelf_decihertz,
    input wire logic signed [15:0] o_shelf_gain_centidb,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [cpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input wire logic [cpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // a stalled result stays and holds its error code, revision and delay
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_error_code)
            && $stable(o_revision) && $stable(o_delay_micros))
        else $error("stalled result changed");

    // a failing check reports no decoded fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != cpc_pkg::ERR_OK |->
            o_enable_flags == 4'h0 && o_revision == 32'h0 && o_delay_micros == 32'h0
            && o_low_pass_decihertz == 16'h0 && o_trim_centidb == 16'sh0
            && o_shelf_decihertz == 16'h0 && o_shelf_gain_centidb == 16'sh0)
        else $error("fields set on failed packet");

    // a result appears only after a last byte request was taken
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte))
        else $error("result without last byte");

    // input stall comes only from a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind config_packet_checker cpc_assertions u_cpc_assertions (.*);

`default_nettype wire
